FILE: rtl/transposition_table_engine_assert.svh
// ---------------------------------------------------------------------------
// Transposition table engine assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_ENGINE_ASSERT_SVH
`define TRANSPOSITION_TABLE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define TTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tte assertion failed");
// antecedent implies consequent in the next cycle
`define TTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tte assertion failed");
`else
`define TTE_ASSERT_IMPL(label, ante, cons)
`define TTE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/tte_pkg.sv
// ---------------------------------------------------------------------------
// tte_pkg
// Shared widths, operation codes and types of the transposition table engine.
// ---------------------------------------------------------------------------
package tte_pkg;

    localparam int DEF_INDEX_BITS = 16;
    localparam int KEY_W          = 64;
    localparam int DEPTH_W        = 7;
    localparam int SCORE_W        = 16;
    localparam int FLAG_W         = 2;
    localparam int SQ_W           = 6;
    localparam int EXTRA_W        = 8;
    localparam int USED_W         = 17;
    localparam int OP_W           = 2;

    localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // stored slot payload; move part packs from | to<<6 | extra<<12
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [SCORE_W-1:0] score;
        logic [FLAG_W-1:0]  flag;
        logic [EXTRA_W-1:0] move_extra;
        logic [SQ_W-1:0]    move_to;
        logic [SQ_W-1:0]    move_from;
    } slot_data_t;

    localparam int SLOT_DATA_W = $bits(slot_data_t);

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tte_mem_ctl_t;

    typedef struct packed {
        logic clearing;
        logic in_flight;
    } tte_status_t;

endpackage

FILE: rtl/tte_if.sv
// ---------------------------------------------------------------------------
// tte_if
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
interface tte_req_if
    import tte_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic [FLAG_W-1:0]  flag;
    logic [SQ_W-1:0]    move_from;
    logic [SQ_W-1:0]    move_to;
    logic [EXTRA_W-1:0] move_extra;

    modport source (output valid, operation, key, depth, score, flag,
                    move_from, move_to, move_extra, input ready);
    modport sink   (input valid, operation, key, depth, score, flag,
                    move_from, move_to, move_extra, output ready);
endinterface

interface tte_rsp_if
    import tte_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [DEPTH_W-1:0] hit_depth;
    logic signed [SCORE_W-1:0] hit_score;
    logic [FLAG_W-1:0]  hit_flag;
    logic [SQ_W-1:0]    hit_move_from;
    logic [SQ_W-1:0]    hit_move_to;
    logic [EXTRA_W-1:0] hit_move_extra;
    logic               replaced;
    logic [USED_W-1:0]  used_count;

    modport source (output valid, hit, hit_depth, hit_score, hit_flag, hit_move_from,
                    hit_move_to, hit_move_extra, replaced, used_count, input ready);
    modport sink   (input valid, hit, hit_depth, hit_score, hit_flag, hit_move_from,
                    hit_move_to, hit_move_extra, replaced, used_count, output ready);
endinterface

FILE: rtl/transposition_table_engine.sv
// ---------------------------------------------------------------------------
// transposition_table_engine
// Direct-mapped table of search results keyed by a 64-bit position hash.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one operation word: probe, store or clear, with key and the
//   result fields to store. rsp returns exactly one word per request: hit
//   fields for a probe, the replaced bit for a store, and the fill count.
//   Probe and store handle one word at a time: the accepted word reads its
//   slot from the single table memory into the read register, then in the
//   LOOKUP state the read data is compared and, for a store that replaces,
//   the slot is written back. The response is registered and is set in the
//   LOOKUP state. A clear answers in the same way, then sweeps all slots,
//   2^INDEX_BITS of them, one slot per cycle, with req not ready. After
//   reset the same sweep runs before the first word is taken. A stalled rsp
//   holds its word; a new request is still taken, and its write-back waits
//   until the response register frees up.
// ---------------------------------------------------------------------------
module transposition_table_engine
    import tte_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    tte_req_if.sink   req,
    tte_rsp_if.source rsp
);

    localparam int WORD_W = 1 + KEY_W - INDEX_BITS + SLOT_DATA_W;

    tte_mem_ctl_t          mem_ctl;
    logic [INDEX_BITS-1:0] rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [WORD_W-1:0]     wr_data;
    tte_status_t           status;

    tte_table #(
        .INDEX_BITS (INDEX_BITS),
        .WORD_W     (WORD_W)
    ) u_table (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    tte_ctrl #(
        .INDEX_BITS (INDEX_BITS),
        .WORD_W     (WORD_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .status  (status)
    );

`include "transposition_table_engine_assert.svh"

    `TTE_ASSERT_IMPL(a_no_accept_in_clear, status.clearing, !req.ready)
    `TTE_ASSERT_NEXT(a_accept_starts_lookup, req.valid && req.ready, status.in_flight)
    `TTE_ASSERT_IMPL(a_no_read_on_write, mem_ctl.wr_en, !mem_ctl.rd_en)
    `TTE_ASSERT_IMPL(a_hit_not_replaced, rsp.valid && rsp.hit, !rsp.replaced)

endmodule

FILE: rtl/tte_table.sv
// ---------------------------------------------------------------------------
// tte_table
// Slot memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tte_table
    import tte_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int WORD_W     = 1 + KEY_W - INDEX_BITS + SLOT_DATA_W
) (
    input  logic                  clk,
    input  tte_mem_ctl_t          mem_ctl,
    input  logic [INDEX_BITS-1:0] rd_addr,
    output logic [WORD_W-1:0]     rd_data,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  logic [WORD_W-1:0]     wr_data
);

    localparam int SLOTS = 1 << INDEX_BITS;

    logic [WORD_W-1:0] slot_mem [SLOTS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tte_ctrl.sv
// ---------------------------------------------------------------------------
// tte_ctrl
// Sequencer: request capture, read-modify-write of one slot, clear sweep,
// fill count and response register.
// ---------------------------------------------------------------------------
module tte_ctrl
    import tte_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int WORD_W     = 1 + KEY_W - INDEX_BITS + SLOT_DATA_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tte_req_if.sink               req,
    tte_rsp_if.source             rsp,
    output tte_mem_ctl_t          mem_ctl,
    output logic [INDEX_BITS-1:0] rd_addr,
    input  logic [WORD_W-1:0]     rd_data,
    output logic [INDEX_BITS-1:0] wr_addr,
    output logic [WORD_W-1:0]     wr_data,
    output tte_status_t           status
);

    localparam int TAG_W = KEY_W - INDEX_BITS;
    localparam int CNT_W = INDEX_BITS + 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

    state_t                state_reg, state_next;
    logic [INDEX_BITS-1:0] clear_ptr_reg, clear_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    slot_data_t            data_reg, data_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  hit_reg, hit_next;
    slot_data_t            hit_data_reg, hit_data_next;
    logic                  replaced_reg, replaced_next;

    logic                  accept;
    logic                  out_free;
    logic                  rd_valid;
    logic [TAG_W-1:0]      rd_tag;
    slot_data_t            rd_info;
    logic                  tag_match;
    logic                  replace;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rd_valid  = rd_data[WORD_W-1];
    assign rd_tag    = rd_data[WORD_W-2 -: TAG_W];
    assign rd_info   = slot_data_t'(rd_data[SLOT_DATA_W-1:0]);
    assign tag_match = (rd_tag == key_reg[KEY_W-1:INDEX_BITS]);
    assign replace   = !rd_valid || !tag_match || (data_reg.depth >= rd_info.depth);

    assign rd_addr   = req.key[INDEX_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clear_ptr_next = clear_ptr_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        hit_next       = hit_reg;
        hit_data_next  = hit_data_reg;
        replaced_next  = replaced_reg;
        mem_ctl.rd_en  = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        wr_addr        = key_reg[INDEX_BITS-1:0];
        wr_data        = {1'b1, key_reg[KEY_W-1:INDEX_BITS], data_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en  = 1'b1;
                wr_addr        = clear_ptr_reg;
                wr_data        = '0;
                clear_ptr_next = clear_ptr_reg + 1'b1;
                if (clear_ptr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_ctl.rd_en = 1'b1;
                    op_next       = req.operation;
                    key_next      = req.key;
                    data_next     = '{depth: req.depth, score: req.score, flag: req.flag,
                                      move_extra: req.move_extra, move_to: req.move_to,
                                      move_from: req.move_from};
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // read data holds until the response register frees up
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    hit_data_next  = '0;
                    replaced_next  = 1'b0;
                    state_next     = ST_IDLE;
                    case (op_reg)
                        OP_PROBE:
                        begin
                            if (rd_valid && tag_match)
                            begin
                                hit_next      = 1'b1;
                                hit_data_next = rd_info;
                            end
                        end
                        OP_STORE:
                        begin
                            if (!rd_valid)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            if (replace)
                            begin
                                mem_ctl.wr_en = 1'b1;
                                replaced_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            clear_ptr_next = '0;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_ptr_reg <= '0;
            count_reg     <= '0;
            op_reg        <= '0;
            key_reg       <= '0;
            data_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            hit_data_reg  <= '0;
            replaced_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_ptr_reg <= clear_ptr_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            data_reg      <= data_next;
            rsp_valid_reg <= rsp_valid_next;
            hit_reg       <= hit_next;
            hit_data_reg  <= hit_data_next;
            replaced_reg  <= replaced_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = hit_reg;
    assign rsp.hit_depth      = hit_data_reg.depth;
    assign rsp.hit_score      = $signed(hit_data_reg.score);
    assign rsp.hit_flag       = hit_data_reg.flag;
    assign rsp.hit_move_from  = hit_data_reg.move_from;
    assign rsp.hit_move_to    = hit_data_reg.move_to;
    assign rsp.hit_move_extra = hit_data_reg.move_extra;
    assign rsp.replaced       = replaced_reg;
    // count is updated together with the response, so it matches the word
    assign rsp.used_count     = USED_W'(count_reg);

    assign status.clearing    = (state_reg == ST_CLEAR);
    assign status.in_flight   = (state_reg == ST_LOOKUP);

endmodule
